// ----- design/bb3e_pkg.sv -----
package bb3e_pkg;

	// channel and pixel widths
	localparam int CH_W  = 8;
	localparam int PIX_W = 3 * CH_W;

	// configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

	// default frame limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// input beat kinds
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// 3x3 window: [column left..right][row top..bottom]
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	// per-beat position info: result wanted, last pixel, neighbor columns/rows in bounds
	typedef struct packed {
		logic produce;
		logic frame_end;
		logic lv;
		logic rv;
		logic tv;
		logic bv;
	} tag_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_end;
	} res_t;

endpackage

// ----- design/bb3e_ram.sv -----
module bb3e_ram #(
	parameter int WIDTH = 2 * bb3e_pkg::PIX_W,
	parameter int DEPTH = bb3e_pkg::MAX_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port, read returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/bb3e_pos.sv -----
module bb3e_pos #(
	parameter int MAX_WIDTH  = bb3e_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bb3e_pkg::MAX_HEIGHT_DEF,
	parameter int CW         = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bb3e_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bb3e_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               acc,
	output logic [CW-1:0]                      col,
	output bb3e_pkg::tag_t                     tag
);

	localparam int WW = $clog2(MAX_WIDTH + 1) + 1;
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	logic [bb3e_pkg::CFG_W-1:0] width_q;
	logic [bb3e_pkg::CFG_W-1:0] height_q;
	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;

	logic [WW-1:0] w;
	logic [RW-1:0] h;
	logic [WW-1:0] col_inc;
	logic          col0;
	logic          at_end;
	logic          started;
	logic          wrap;

	// frame size in use: zero acts as one, oversize acts as the maximum
	always_comb begin
		if (width_q == '0) begin
			w = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(width_q);
		end
		if (height_q == '0) begin
			h = RW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h = RW'(MAX_HEIGHT);
		end else begin
			h = RW'(height_q);
		end
	end

	// window center sits one row and one pixel behind the incoming beat
	always_comb begin
		col0          = (col_q == '0);
		at_end        = (32'(row_q) == 32'(h) + 32'd1) && col0;
		started       = (32'(row_q) >= 32'd2) || ((32'(row_q) == 32'd1) && !col0);
		tag.produce   = started && ((32'(row_q) <= 32'(h)) || at_end);
		tag.frame_end = at_end;
		tag.lv        = col0 ? (32'(w) >= 32'd2) : (32'(col_q) >= 32'd2);
		tag.rv        = !col0;
		tag.tv        = col0 ? (32'(row_q) >= 32'd3) : (32'(row_q) >= 32'd2);
		tag.bv        = col0 ? (32'(row_q) <= 32'(h)) : (row_q < h);
		col_inc       = WW'(col_q) + WW'(1);
		wrap          = (col_inc >= w);
	end

	assign col = col_q;

	// registers and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bb3e_pkg::DIM_RESET;
			height_q <= bb3e_pkg::DIM_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bb3e_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bb3e_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (tag.produce && at_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

endmodule

// ----- design/bb3e_win.sv -----
module bb3e_win #(
	parameter int MAX_WIDTH = bb3e_pkg::MAX_WIDTH_DEF,
	parameter int CW        = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           acc,
	input  logic [CW-1:0]  col,
	input  bb3e_pkg::pix_t px,
	input  bb3e_pkg::tag_t tag_in,
	output bb3e_pkg::win_t win,
	output bb3e_pkg::tag_t tag_s2,
	output logic           valid_s2
);

	localparam int PW = bb3e_pkg::PIX_W;
	localparam int LW = 2 * PW;

	logic           v_s1;
	logic           v_s2;
	logic [CW-1:0]  col_s1;
	bb3e_pkg::pix_t px_s1;
	bb3e_pkg::tag_t tag_s1;
	bb3e_pkg::tag_t tag_q_s2;
	logic           fwd_s1;
	logic [LW-1:0]  fwd_data_s1;
	bb3e_pkg::win_t win_q;

	logic [LW-1:0]  rdata;
	logic [LW-1:0]  line_s1;
	logic [LW-1:0]  wdata;
	logic           we;
	bb3e_pkg::pix_t up;
	bb3e_pkg::pix_t mid;

	// line store entry per column: {upper row, middle row}
	bb3e_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (we),
		.waddr(col_s1),
		.wdata(wdata),
		.re   (acc),
		.raddr(col),
		.rdata(rdata)
	);

	// read-modify-write, forward when the previous beat wrote the same column
	always_comb begin
		line_s1 = fwd_s1 ? fwd_data_s1 : rdata;
		up      = line_s1[LW-1:PW];
		mid     = line_s1[PW-1:0];
		we      = v_s1 && adv;
		wdata   = {mid, px_s1};
	end

	// control and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			win_q <= '0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			if (v_s1) begin
				win_q[0]    <= win_q[1];
				win_q[1]    <= win_q[2];
				win_q[2][0] <= up;
				win_q[2][1] <= mid;
				win_q[2][2] <= px_s1;
			end
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_q_s2 <= tag_s1;
			if (acc) begin
				col_s1      <= col;
				px_s1       <= px;
				tag_s1      <= tag_in;
				fwd_s1      <= we && (col_s1 == col);
				fwd_data_s1 <= wdata;
			end
		end
	end

	assign win      = win_q;
	assign tag_s2   = tag_q_s2;
	assign valid_s2 = v_s2;

endmodule

// ----- design/bb3e_avg.sv -----
module bb3e_avg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           valid_s2,
	input  bb3e_pkg::tag_t tag_s2,
	input  bb3e_pkg::win_t win,
	output logic           push,
	output bb3e_pkg::res_t res
);

	localparam int CH_W     = bb3e_pkg::CH_W;
	localparam int PW       = bb3e_pkg::PIX_W;
	localparam int CS_W     = CH_W + 2;
	localparam int TOT_W    = CH_W + 4;
	localparam int N_W      = TOT_W + 1;
	localparam int RCP_W    = 16;
	localparam int RCP_SH   = 17;
	localparam int PROD_W   = N_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP3 = 16'd43691;
	localparam logic [RCP_W-1:0] RECIP9 = 16'd14564;

	typedef enum logic [1:0] {
		FAC_1,
		FAC_3,
		FAC_9
	} fac_t;

	logic [2:0]                       rowm;
	logic [2:0]                       colm;
	logic [3:0]                       nc;
	logic [3:0]                       nr;
	logic [3:0]                       cnt;
	logic [2:0][2:0][CS_W-1:0]        csum;

	logic                             v_s3;
	logic [2:0][2:0][CS_W-1:0]        csum_s3;
	logic [2:0]                       colm_s3;
	logic [3:0]                       cnt_s3;
	logic                             fe_s3;

	logic [2:0][TOT_W-1:0]            tot;
	logic [2:0][N_W-1:0]              nsum;
	logic [2:0][N_W-1:0]              xv;
	logic [1:0]                       k;
	fac_t                             fac;

	logic                             v_s4;
	logic [2:0][N_W-1:0]              x_s4;
	fac_t                             fac_s4;
	logic                             fe_s4;

	logic [2:0][PROD_W-1:0]           prod;
	logic [2:0][CH_W-1:0]             q;

	// column sums over rows in bounds
	always_comb begin
		rowm = {tag_s2.bv, 1'b1, tag_s2.tv};
		colm = {tag_s2.rv, 1'b1, tag_s2.lv};
		nc   = 4'd1 + 4'(tag_s2.lv) + 4'(tag_s2.rv);
		nr   = 4'd1 + 4'(tag_s2.tv) + 4'(tag_s2.bv);
		cnt  = 4'(nc * nr);
		for (int a = 0; a < 3; a++) begin
			for (int ch = 0; ch < 3; ch++) begin
				csum[a][ch] = '0;
				for (int b = 0; b < 3; b++) begin
					if (rowm[b]) begin
						csum[a][ch] = csum[a][ch]
							+ CS_W'(win[a][b][PW-1-ch*CH_W -: CH_W]);
					end
				end
			end
		end
	end

	// total, then 2*sum+count scaled down by the power-of-two part of 2*count
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot[ch] = '0;
			for (int a = 0; a < 3; a++) begin
				if (colm_s3[a]) begin
					tot[ch] = tot[ch] + TOT_W'(csum_s3[a][ch]);
				end
			end
			nsum[ch] = {tot[ch], 1'b0} + N_W'(cnt_s3);
		end
		unique case (cnt_s3)
			4'd1:    begin k = 2'd1; fac = FAC_1; end
			4'd2:    begin k = 2'd2; fac = FAC_1; end
			4'd3:    begin k = 2'd1; fac = FAC_3; end
			4'd4:    begin k = 2'd3; fac = FAC_1; end
			4'd6:    begin k = 2'd2; fac = FAC_3; end
			4'd9:    begin k = 2'd1; fac = FAC_9; end
			default: begin k = 2'd1; fac = FAC_1; end
		endcase
		for (int ch = 0; ch < 3; ch++) begin
			xv[ch] = nsum[ch] >> k;
		end
	end

	// odd factor by reciprocal multiply, exact over this range
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			unique case (fac_s4)
				FAC_3:   prod[ch] = PROD_W'(x_s4[ch]) * PROD_W'(RECIP3);
				FAC_9:   prod[ch] = PROD_W'(x_s4[ch]) * PROD_W'(RECIP9);
				default: prod[ch] = PROD_W'(x_s4[ch]) << RCP_SH;
			endcase
			q[ch] = prod[ch][RCP_SH +: CH_W];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= valid_s2 && tag_s2.produce;
			v_s4 <= v_s3;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			csum_s3 <= csum;
			colm_s3 <= colm;
			cnt_s3  <= cnt;
			fe_s3   <= tag_s2.frame_end;
			x_s4    <= xv;
			fac_s4  <= fac;
			fe_s4   <= fe_s3;
		end
	end

	assign push          = adv && v_s4;
	assign res.red       = q[0];
	assign res.green     = q[1];
	assign res.blue      = q[2];
	assign res.frame_end = fe_s4;

endmodule

// ----- design/bb3e_outq.sv -----
module bb3e_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bb3e_pkg::res_t din,
	output logic           out_valid,
	input  logic           out_stall,
	output bb3e_pkg::res_t dout,
	output logic           full
);

	bb3e_pkg::res_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           pop;

	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign dout      = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// result beats
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ----- design/box_blur_3x3_edge_aware_unit.sv -----
// Edge-aware 3x3 box blur on a raster stream of RGB pixels, one pixel per clock
// sustained while the output queue has room. Each input beat is read against a
// line store entry for its column (the two rows above it) and written back from
// the stage-1 registers once the pipeline advances; that single read-modify-write
// per beat on the line store RAM sets the rate at one beat per cycle. Results
// trail the pixel stream by one row plus one pixel, so after the last pixel of a
// frame send image_width+1 beats with mode set to flush it. The line store needs
// no clearing after reset: entries never written are only read for rows above
// the image, which never count. Any register write restarts the frame position.
// in_stall rises only while two results wait unclaimed.
module box_blur_3x3_edge_aware_unit #(
	parameter int MAX_WIDTH  = bb3e_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bb3e_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bb3e_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bb3e_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [bb3e_pkg::CH_W-1:0]      pixel_red,
	input  logic [bb3e_pkg::CH_W-1:0]      pixel_green,
	input  logic [bb3e_pkg::CH_W-1:0]      pixel_blue,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bb3e_pkg::CH_W-1:0]      blur_red,
	output logic [bb3e_pkg::CH_W-1:0]      blur_green,
	output logic [bb3e_pkg::CH_W-1:0]      blur_blue,
	output logic                           frame_end
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic           acc;
	logic           adv;
	logic           full;
	logic [CW-1:0]  col;
	bb3e_pkg::tag_t tag;
	bb3e_pkg::pix_t px;
	bb3e_pkg::win_t win;
	bb3e_pkg::tag_t tag_s2;
	logic           valid_s2;
	logic           push;
	bb3e_pkg::res_t res;
	bb3e_pkg::res_t dout;

	// pipeline moves whenever the output queue has room
	assign adv      = !full;
	assign in_stall = full;
	assign acc      = in_valid && adv;
	assign px       = (mode == bb3e_pkg::MODE_FLUSH) ? '0
	                                                 : {pixel_red, pixel_green, pixel_blue};

	bb3e_pos #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.CW        (CW)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.acc      (acc),
		.col      (col),
		.tag      (tag)
	);

	bb3e_win #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW       (CW)
	) u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.acc     (acc),
		.col     (col),
		.px      (px),
		.tag_in  (tag),
		.win     (win),
		.tag_s2  (tag_s2),
		.valid_s2(valid_s2)
	);

	bb3e_avg u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_s2(valid_s2),
		.tag_s2  (tag_s2),
		.win     (win),
		.push    (push),
		.res     (res)
	);

	bb3e_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (res),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dout     (dout),
		.full     (full)
	);

	assign blur_red   = dout.red;
	assign blur_green = dout.green;
	assign blur_blue  = dout.blue;
	assign frame_end  = dout.frame_end;

endmodule

// ----- design/bb3e_chk.sv -----
module bb3e_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [bb3e_pkg::CH_W-1:0] blur_red,
	input logic [bb3e_pkg::CH_W-1:0] blur_green,
	input logic [bb3e_pkg::CH_W-1:0] blur_blue,
	input logic                      frame_end
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blur_red) && $stable(blur_green)
			&& $stable(blur_blue) && $stable(frame_end))
		else $error("result beat changed while stalled");

	// input is held off only while results are waiting
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// the queue only fills up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without an earlier output stall");

	// a taken result always frees room for the next beat
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !in_stall)
		else $error("input stalled right after a result was taken");

endmodule

bind box_blur_3x3_edge_aware_unit bb3e_chk u_chk (.*);

// ----- tb/sv/box_blur_checker.sv -----
module box_blur_checker #(
	parameter int MAX_W = bb3e_pkg::MAX_WIDTH_DEF,
	parameter int MAX_H = bb3e_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bb3e_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bb3e_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           mode,
	input  logic [bb3e_pkg::CH_W-1:0]      pixel_red,
	input  logic [bb3e_pkg::CH_W-1:0]      pixel_green,
	input  logic [bb3e_pkg::CH_W-1:0]      pixel_blue,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [bb3e_pkg::CH_W-1:0]      blur_red,
	input  logic [bb3e_pkg::CH_W-1:0]      blur_green,
	input  logic [bb3e_pkg::CH_W-1:0]      blur_blue,
	input  logic                           frame_end,
	output int                             mismatches,
	output int                             outstanding,
	output int                             compared
);

	// frame size registers as last written
	logic [bb3e_pkg::CFG_W-1:0] width_reg;
	logic [bb3e_pkg::CFG_W-1:0] height_reg;

	// two rows above the incoming one, and the 3x3 window [column][row]
	bb3e_pkg::pix_t upper_line [MAX_W];
	bb3e_pkg::pix_t middle_line [MAX_W];
	bb3e_pkg::pix_t win [3][3];

	// position of the next beat within the frame
	int beat_idx;
	int col_pos;
	int row_pos;

	// blurred pixels predicted but not yet seen on the output
	bb3e_pkg::res_t awaited_blur [$];

	int fails = 0;
	int checks = 0;

	// zero acts as one, oversize acts as the maximum
	function automatic int usable_dim(input logic [bb3e_pkg::CFG_W-1:0] v, input int lim);
		if (v == 0)
			return 1;
		if (int'(v) > lim)
			return lim;
		return int'(v);
	endfunction

	function automatic void restart_frame();
		beat_idx = 0;
		col_pos = 0;
		row_pos = 0;
	endfunction

	// advance the window and line stores by one beat, queue the blurred pixel it yields
	function automatic void predict_blur(input logic m, input bb3e_pkg::pix_t colour);
		int w, h, total, col;
		int a, b, cr, cc, rr, cn;
		int unsigned sum_r, sum_g, sum_b, cnt;
		bb3e_pkg::pix_t px, v;
		bb3e_pkg::res_t r;
		logic produced;
		w = usable_dim(width_reg, MAX_W);
		h = usable_dim(height_reg, MAX_H);
		total = w * h;
		col = (col_pos >= MAX_W) ? 0 : col_pos;
		px = (m == bb3e_pkg::MODE_FLUSH) ? '0 : colour;

		// slide left, new right column is upper, middle, incoming
		for (a = 0; a < 2; a++)
			for (b = 0; b < 3; b++)
				win[a][b] = win[a + 1][b];
		win[2][0] = upper_line[col];
		win[2][1] = middle_line[col];
		win[2][2] = px;
		upper_line[col] = middle_line[col];
		middle_line[col] = px;

		produced = 1'b0;
		if (beat_idx >= w + 1 && beat_idx <= total + w) begin
			// centre sits one pixel back, wrapping to the previous row end
			if (col >= 1) begin
				cc = col - 1;
				cr = row_pos - 1;
			end else begin
				cc = w - 1;
				cr = row_pos - 2;
			end
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			cnt = 0;
			for (a = -1; a <= 1; a++) begin
				rr = cr + a;
				if (rr >= 0 && rr <= h - 1) begin
					for (b = -1; b <= 1; b++) begin
						cn = cc + b;
						if (cn >= 0 && cn <= w - 1) begin
							v = win[b + 1][a + 1];
							sum_r += v[23:16];
							sum_g += v[15:8];
							sum_b += v[7:0];
							cnt++;
						end
					end
				end
			end
			if (cnt == 0)
				cnt = 1;
			// round half up
			r.red = 8'((2 * sum_r + cnt) / (2 * cnt));
			r.green = 8'((2 * sum_g + cnt) / (2 * cnt));
			r.blue = 8'((2 * sum_b + cnt) / (2 * cnt));
			r.frame_end = (beat_idx == total + w);
			awaited_blur.push_back(r);
			produced = 1'b1;
		end

		if (produced && beat_idx == total + w) begin
			restart_frame();
		end else begin
			beat_idx++;
			col++;
			if (col >= w) begin
				col = 0;
				row_pos++;
			end
			col_pos = col;
		end
	endfunction

	task automatic note_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (fails < 30)
			$display("mismatch at result %0d: %s is %0h, predicted %0h", checks, what, got,
				want);
		fails++;
	endtask

	task automatic check_blur();
		bb3e_pkg::res_t e;
		if (awaited_blur.size() == 0) begin
			note_mismatch("output beat with no pixel awaited, red", blur_red, 8'h00);
		end else begin
			e = awaited_blur.pop_front();
			checks++;
			if (blur_red !== e.red)
				note_mismatch("blur_red", blur_red, e.red);
			if (blur_green !== e.green)
				note_mismatch("blur_green", blur_green, e.green);
			if (blur_blue !== e.blue)
				note_mismatch("blur_blue", blur_blue, e.blue);
			if (frame_end !== e.frame_end)
				note_mismatch("frame_end", {7'd0, frame_end}, {7'd0, e.frame_end});
		end
	endtask

	// watch all three ports on each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = bb3e_pkg::DIM_RESET;
			height_reg = bb3e_pkg::DIM_RESET;
			for (int i = 0; i < MAX_W; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win[i][j] = '0;
			awaited_blur.delete();
			restart_frame();
		end else begin
			// output beat is compared before this edge's input beat is predicted
			if (out_valid && !out_stall)
				check_blur();
			// any register write restarts the frame
			if (cfg_we) begin
				if (cfg_index == bb3e_pkg::REG_IMAGE_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == bb3e_pkg::REG_IMAGE_HEIGHT)
					height_reg = cfg_data;
				restart_frame();
			end
			if (in_valid && !in_stall)
				predict_blur(mode, {pixel_red, pixel_green, pixel_blue});
		end
		mismatches <= fails;
		outstanding <= awaited_blur.size();
		compared <= checks;
	end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BEATS = 300;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [bb3e_pkg::CFG_IDX_W-1:0] cfg_index = bb3e_pkg::REG_IMAGE_WIDTH;
	logic [bb3e_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           mode = bb3e_pkg::MODE_PIXEL;
	logic [bb3e_pkg::CH_W-1:0]      pixel_red = '0;
	logic [bb3e_pkg::CH_W-1:0]      pixel_green = '0;
	logic [bb3e_pkg::CH_W-1:0]      pixel_blue = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [bb3e_pkg::CH_W-1:0]      blur_red;
	logic [bb3e_pkg::CH_W-1:0]      blur_green;
	logic [bb3e_pkg::CH_W-1:0]      blur_blue;
	logic                           frame_end;

	int mismatches;
	int outstanding;
	int compared;

	// stimulus controls shared with the output stall process
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	int beats_sent = 0;
	int sizes_used = 0;

	box_blur_3x3_edge_aware_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.pixel_red  (pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue (pixel_blue),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.blur_red   (blur_red),
		.blur_green (blur_green),
		.blur_blue  (blur_blue),
		.frame_end  (frame_end)
	);

	box_blur_checker blur_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.pixel_red  (pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue (pixel_blue),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.blur_red   (blur_red),
		.blur_green (blur_green),
		.blur_blue  (blur_blue),
		.frame_end  (frame_end),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.compared   (compared)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// output stall: random, one long hold on request, none while calm
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !calm && ($urandom_range(99) < 32);
		end
	end

	// channel level biased toward the extremes
	function automatic logic [bb3e_pkg::CH_W-1:0] pick_level();
		unique case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic m, input logic [bb3e_pkg::CH_W-1:0] r,
			input logic [bb3e_pkg::CH_W-1:0] g, input logic [bb3e_pkg::CH_W-1:0] b);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		pixel_red <= r;
		pixel_green <= g;
		pixel_blue <= b;
		do
			@(posedge clk);
		while (in_stall);
		beats_sent++;
	endtask

	// stop offering until every predicted pixel has come out, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame_size(input int w, input int h);
		cfg_we <= 1'b1;
		cfg_index <= bb3e_pkg::REG_IMAGE_WIDTH;
		cfg_data <= 11'(w);
		@(posedge clk);
		cfg_index <= bb3e_pkg::REG_IMAGE_HEIGHT;
		cfg_data <= 11'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		sizes_used++;
	endtask

	// pixel beats then flush beats; noise swaps the beat kind, pause_at drains mid-frame
	task automatic send_frame(input int n_pix, input int n_tail, input int noise,
			input int pause_at);
		for (int i = 0; i < n_pix; i++) begin
			if (i == pause_at)
				wait_idle();
			send_beat(($urandom_range(99) < noise) ? bb3e_pkg::MODE_FLUSH
				: bb3e_pkg::MODE_PIXEL, pick_level(), pick_level(), pick_level());
		end
		for (int i = 0; i < n_tail; i++)
			send_beat(($urandom_range(99) < noise) ? bb3e_pkg::MODE_PIXEL
				: bb3e_pkg::MODE_FLUSH, pick_level(), pick_level(), pick_level());
	endtask

	initial begin
		int wid, hgt, cw, ch, n_frames, kind, base;
		logic paused;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame: corners, edges, centre; a flush beat inside the pixels counts
		// as black and a real pixel inside the flush tail is ignored
		set_frame_size(3, 3);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'hff, 8'hff, 8'hff);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'h00, 8'hff, 8'h00);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'hff, 8'h00, 8'h01);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'h01, 8'h80, 8'hff);
		send_beat(bb3e_pkg::MODE_FLUSH, 8'hff, 8'hff, 8'hff);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'h7f, 8'h00, 8'hfe);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'h00, 8'h00, 8'h00);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'hff, 8'h01, 8'h80);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'hfe, 8'hff, 8'h7f);
		send_beat(bb3e_pkg::MODE_FLUSH, 8'h00, 8'h00, 8'h00);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'hff, 8'hff, 8'hff);
		send_beat(bb3e_pkg::MODE_FLUSH, 8'hff, 8'h00, 8'hff);
		send_beat(bb3e_pkg::MODE_FLUSH, 8'h00, 8'h00, 8'h00);
		wait_idle();

		// zero sizes act as a single pixel
		set_frame_size(0, 0);
		send_beat(bb3e_pkg::MODE_PIXEL, 8'hff, 8'h00, 8'h81);
		send_beat(bb3e_pkg::MODE_FLUSH, 8'h00, 8'h00, 8'h00);
		send_beat(bb3e_pkg::MODE_FLUSH, 8'h00, 8'h00, 8'h00);
		wait_idle();

		// oversize registers clamp; the frame is cut short by the next write
		set_frame_size(2047, 2047);
		send_frame(6, 0, 0, -1);
		wait_idle();

		// widest row, cut short in the flush tail, with a long output hold
		// while the tail keeps coming
		set_frame_size(1024, 1);
		send_frame(1024, 0, 2, -1);
		hold_req <= 1'b1;
		send_frame(0, 200, 2, -1);
		wait_idle();

		// tall column with no idle cycles on either side
		calm <= 1'b1;
		set_frame_size(1, 100);
		send_frame(100, 2, 0, -1);
		wait_idle();
		calm <= 1'b0;

		// random small frames, mostly well formed
		base = beats_sent;
		paused = 1'b0;
		while (beats_sent - base < RANDOM_BEATS) begin
			wid = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 12);
			hgt = (wid > 16) ? $urandom_range(1, 3) : $urandom_range(0, 12);
			cw = (wid == 0) ? 1 : wid;
			ch = (hgt == 0) ? 1 : hgt;
			set_frame_size(wid, hgt);
			n_frames = $urandom_range(1, 3);
			for (int f = 0; f < n_frames; f++) begin
				kind = $urandom_range(99);
				if (kind < 10) begin
					// abandoned part way, the next size write restarts it
					send_frame($urandom_range(1, cw * ch), 0, 5, -1);
					break;
				end else if (kind < 20) begin
					send_frame(cw * ch, $urandom_range(0, cw + 3), 5, -1);
				end else if (!paused && cw * ch >= 4) begin
					send_frame(cw * ch, cw + 1, 0, cw * ch / 2);
					paused = 1'b1;
				end else begin
					send_frame(cw * ch, cw + 1, (kind < 40) ? 6 : 0, -1);
				end
			end
			wait_idle();
		end

		$display("sent %0d input beats over %0d frame sizes, compared %0d blurred pixels",
			beats_sent, sizes_used, compared);
		$display("covered corner, edge and one-pixel frames, clamped sizes, stray beat kinds,"
			, " cut frames and a long output hold");
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// time limit
	initial begin
		#(8 * 400000);
		$display("run stopped at the time limit, %0d pixels still awaited", outstanding);
		$display("status: fail");
		$finish;
	end

endmodule
